>>> src/rmth_pkg.sv
// Package for the two-heap running median block.
// Holds the heap depth constant, the widths and the state and operation types; no dependencies.
package rmth_pkg;
    localparam int HeapDepth = 512;
    localparam int AddrW     = $clog2(HeapDepth);
    localparam int SizeW     = $clog2(HeapDepth + 1);
    localparam int CountW    = 11;
    localparam int ValueW    = 32;
    localparam int MedW      = 33;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DEC    = 10'b0000000010,
        S_UPRD   = 10'b0000000100,
        S_UPCHK  = 10'b0000001000,
        S_DNRD   = 10'b0000010000,
        S_DNCHK  = 10'b0000100000,
        S_NEXT   = 10'b0001000000,
        S_TOPRD  = 10'b0010000000,
        S_TOPGET = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PUSHPOP = 2'd1,
        OP_POP     = 2'd2
    } t_op;
endpackage

>>> src/running_median_two_heaps_top.sv
// Top level of the two-heap running median block, a sequencer over two heap memories.
// Depends on rmth_pkg. A push walk passes S_UPRD and S_UPCHK per heap level and a sift-down
// walk S_DNRD and two S_DNCHK phases, since each level waits on a memory read; a stored
// item runs one to three walks. The block takes one item at a time: a new input is taken
// only in S_IDLE, after the result is registered; a waiting result stalls only the last step.
// Synchronous active-low reset empties both heaps; no clearing pass.
module running_median_two_heaps_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // median_doubled[32:0], stored_count[43:33], overflow[44]
);
    localparam int AW = rmth_pkg::AddrW;
    localparam int SW = rmth_pkg::SizeW;
    localparam int CountW = rmth_pkg::CountW;

    logic signed [31:0] r_mem_lo [rmth_pkg::HeapDepth];
    logic signed [31:0] r_mem_hi [rmth_pkg::HeapDepth];
    logic signed [31:0] r_rd_lo, r_rd_hi;

    rmth_pkg::t_state r_state, n_state;
    rmth_pkg::t_op    r_op, n_op;
    logic [SW-1:0] r_lsz, n_lsz, r_usz, n_usz;
    logic signed [31:0] r_v, n_v, r_top_lo, n_top_lo, r_top_hi, n_top_hi;
    logic signed [31:0] r_cur, n_cur, r_cv, n_cv, r_lc, n_lc;
    logic signed [31:0] r_carry, n_carry;
    logic r_heap, n_heap, r_second, n_second, r_ovf, n_ovf, r_ph, n_ph;
    logic [SW-1:0] r_i, n_i, r_n, n_n;
    logic [AW-1:0] r_best, n_best;
    logic r_has_r, n_has_r;
    logic r_busy_rb, n_busy_rb;
    logic r_oval, n_oval;
    logic [47:0] r_odata, n_odata;

    logic we_lo, we_hi;
    logic [AW-1:0] wa, ra;
    logic signed [31:0] wd;
    logic signed [32:0] m2;

    always_ff @(posedge i_clk) begin
        if (we_lo) r_mem_lo[wa] <= wd;
        if (we_hi) r_mem_hi[wa] <= wd;
        r_rd_lo <= r_mem_lo[ra];
        r_rd_hi <= r_mem_hi[ra];
    end

    // heap=1: lower (max) heap; ahead(a,b)
    function automatic logic ahead(input logic mx, input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        ahead = mx ? (a > b) : (a < b);
    endfunction

    logic signed [31:0] rd;
    assign rd = r_heap ? r_rd_lo : r_rd_hi;
    assign s_axis_tready = (r_state == rmth_pkg::S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_state = r_state; n_op = r_op; n_lsz = r_lsz; n_usz = r_usz; n_v = r_v;
        n_top_lo = r_top_lo; n_top_hi = r_top_hi; n_cur = r_cur; n_cv = r_cv; n_lc = r_lc;
        n_carry = r_carry; n_heap = r_heap; n_second = r_second; n_ovf = r_ovf;
        n_ph = r_ph; n_i = r_i; n_n = r_n; n_best = r_best; n_has_r = r_has_r;
        n_busy_rb = r_busy_rb; n_oval = r_oval; n_odata = r_odata;
        we_lo = 1'b0; we_hi = 1'b0; wa = '0; wd = '0; ra = '0; m2 = '0;
        if (m_axis_tready) n_oval = 1'b0;
        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_v = s_axis_tdata;
                    n_ovf = 1'b0;
                    n_state = rmth_pkg::S_DEC;
                end
            end
            rmth_pkg::S_DEC: begin
                n_second = 1'b0; n_busy_rb = 1'b0;
                if (r_lsz == SW'(rmth_pkg::HeapDepth) && r_usz == SW'(rmth_pkg::HeapDepth)) begin
                    n_ovf = 1'b1;
                    n_state = rmth_pkg::S_TOPRD;
                end else begin
                    n_heap = (r_lsz == '0) || (r_v <= r_top_lo);
                    if (n_heap ? (r_lsz < SW'(rmth_pkg::HeapDepth))
                               : (r_usz < SW'(rmth_pkg::HeapDepth))) begin
                        n_op = rmth_pkg::OP_PUSH;
                    end else begin
                        n_op = rmth_pkg::OP_PUSHPOP;
                    end
                    n_carry = r_v;
                    n_state = rmth_pkg::S_NEXT;
                end
            end
            rmth_pkg::S_NEXT: begin
                // start operation r_op on heap r_heap with value r_carry
                unique case (r_op)
                    rmth_pkg::OP_PUSH: begin
                        n_i = r_heap ? r_lsz : r_usz;
                        if (r_heap) n_lsz = r_lsz + 1'b1; else n_usz = r_usz + 1'b1;
                        n_cur = r_carry;
                        n_state = rmth_pkg::S_UPRD;
                    end
                    rmth_pkg::OP_PUSHPOP: begin
                        if (!ahead(r_heap, r_heap ? r_top_lo : r_top_hi, r_carry)) begin
                            n_heap = !r_heap; n_op = rmth_pkg::OP_PUSH;
                            n_second = 1'b1;
                        end else begin
                            n_lc = r_heap ? r_top_lo : r_top_hi;
                            n_cur = r_carry; n_i = '0;
                            n_n = r_heap ? r_lsz : r_usz;
                            n_ph = 1'b1;
                            n_state = rmth_pkg::S_DNRD;
                        end
                    end
                    default: begin
                        n_lc = r_heap ? r_top_lo : r_top_hi;
                        if (r_heap) n_lsz = r_lsz - 1'b1; else n_usz = r_usz - 1'b1;
                        n_n = (r_heap ? r_lsz : r_usz) - 1'b1;
                        ra = AW'(n_n);
                        n_i = '0; n_ph = 1'b0;
                        n_state = rmth_pkg::S_DNRD;
                    end
                endcase
            end
            rmth_pkg::S_UPRD: begin
                if (r_i == '0) begin
                    wa = '0; wd = r_cur;
                    we_lo = r_heap; we_hi = !r_heap;
                    if (r_heap) n_top_lo = r_cur; else n_top_hi = r_cur;
                    n_state = rmth_pkg::S_TOPRD;
                end else begin
                    ra = AW'((r_i - 1'b1) >> 1);
                    n_state = rmth_pkg::S_UPCHK;
                end
            end
            rmth_pkg::S_UPCHK: begin
                wa = AW'(r_i);
                if (ahead(r_heap, r_cur, rd)) begin
                    wd = rd; n_i = (r_i - 1'b1) >> 1;
                    n_state = rmth_pkg::S_UPRD;
                end else begin
                    wd = r_cur;
                    n_state = rmth_pkg::S_TOPRD;
                end
                we_lo = r_heap; we_hi = !r_heap;
            end
            rmth_pkg::S_DNRD: begin
                // phase 0: fetch last element as the sift value
                if (!r_ph) begin
                    n_cur = rd; n_ph = 1'b1;
                end else if ({r_i, 1'b1} < {1'b0, r_n}) begin
                    ra = AW'({r_i, 1'b1});
                    n_has_r = ({r_i, 1'b0} + 2'd2) < {1'b0, r_n};
                    n_state = rmth_pkg::S_DNCHK;
                    n_ph = 1'b0;
                end else begin
                    wa = AW'(r_i); wd = r_cur;
                    we_lo = r_heap; we_hi = !r_heap;
                    if (r_i == '0 && r_n != '0) begin
                        if (r_heap) n_top_lo = r_cur; else n_top_hi = r_cur;
                    end
                    n_state = rmth_pkg::S_TOPRD;
                end
            end
            rmth_pkg::S_DNCHK: begin
                if (!r_ph) begin
                    n_cv = rd; n_best = AW'({r_i, 1'b1});
                    ra = AW'({r_i, 1'b0} + 2'd2);
                    n_ph = 1'b1;
                end else begin
                    logic signed [31:0] c;
                    logic [AW-1:0] b;
                    c = r_cv; b = r_best;
                    if (r_has_r && ahead(r_heap, rd, c)) begin
                        c = rd; b = AW'({r_i, 1'b0} + 2'd2);
                    end
                    wa = AW'(r_i);
                    we_lo = r_heap; we_hi = !r_heap;
                    if (ahead(r_heap, c, r_cur)) begin
                        wd = c;
                        if (r_i == '0) begin
                            if (r_heap) n_top_lo = c; else n_top_hi = c;
                        end
                        n_i = SW'(b);
                        n_state = rmth_pkg::S_DNRD;
                    end else begin
                        wd = r_cur;
                        if (r_i == '0) begin
                            if (r_heap) n_top_lo = r_cur; else n_top_hi = r_cur;
                        end
                        n_state = rmth_pkg::S_TOPRD;
                    end
                end
            end
            rmth_pkg::S_TOPRD: begin
                // operation finished; chain follow-ups
                if ((r_op == rmth_pkg::OP_PUSHPOP || r_op == rmth_pkg::OP_POP) && !r_second) begin
                    n_second = 1'b1; n_heap = !r_heap; n_op = rmth_pkg::OP_PUSH;
                    n_carry = r_lc; n_state = rmth_pkg::S_NEXT;
                end else if (!r_busy_rb && !r_ovf && r_lsz > r_usz + 1'b1
                             && r_usz < SW'(rmth_pkg::HeapDepth)) begin
                    n_busy_rb = 1'b1; n_second = 1'b0; n_heap = 1'b1;
                    n_op = rmth_pkg::OP_POP; n_state = rmth_pkg::S_NEXT;
                end else if (!r_busy_rb && !r_ovf && r_usz > r_lsz + 1'b1
                             && r_lsz < SW'(rmth_pkg::HeapDepth)) begin
                    n_busy_rb = 1'b1; n_second = 1'b0; n_heap = 1'b0;
                    n_op = rmth_pkg::OP_POP; n_state = rmth_pkg::S_NEXT;
                end else begin
                    n_state = rmth_pkg::S_TOPGET;
                end
            end
            rmth_pkg::S_TOPGET: begin
                n_state = rmth_pkg::S_OUT;
            end
            default: begin
                if (!r_oval || m_axis_tready) begin
                    if (r_lsz == r_usz) begin
                        if (r_lsz != '0) m2 = 33'(r_top_lo) + 33'(r_top_hi);
                    end else if (r_lsz > r_usz) begin
                        m2 = {r_top_lo, 1'b0};
                    end else begin
                        m2 = {r_top_hi, 1'b0};
                    end
                    n_odata = {3'b0, r_ovf, CountW'(r_lsz) + CountW'(r_usz), m2};
                    n_oval = 1'b1;
                    n_state = rmth_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmth_pkg::S_IDLE;
            r_lsz <= '0; r_usz <= '0; r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lsz <= n_lsz; r_usz <= n_usz; r_oval <= n_oval;
        end
        r_op <= n_op; r_v <= n_v; r_top_lo <= n_top_lo; r_top_hi <= n_top_hi;
        r_cur <= n_cur; r_cv <= n_cv; r_lc <= n_lc; r_carry <= n_carry; r_heap <= n_heap;
        r_second <= n_second; r_ovf <= n_ovf; r_ph <= n_ph; r_i <= n_i; r_n <= n_n;
        r_best <= n_best; r_has_r <= n_has_r; r_busy_rb <= n_busy_rb; r_odata <= n_odata;
    end
endmodule
